@@ rtl/bba_pkg.sv @@
// Shared types, codes and constants for the bid budget arbiter.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package bba_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DIV_STEPS = 16;
   localparam logic [15:0] LFSR_TAPS = 16'hB400;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_SET_BID  = 3'd1,
      OP_SET_RDY  = 3'd2,
      OP_GRANT    = 3'd3,
      OP_CHARGE   = 3'd4,
      OP_REFILL   = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_UNREG = 2'd2
   } op_status_type;

   typedef enum logic [1:0] {
      MODE_RANDOM  = 2'd0,
      MODE_RR      = 2'd1,
      MODE_HIGHEST = 2'd2,
      MODE_SECOND  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_NEW    = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_BROKE  = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      CFG_MODE    = 3'd0,
      CFG_MIN_BID = 3'd1,
      CFG_MAX_BID = 3'd2,
      CFG_INIT    = 3'd3,
      CFG_REFILL  = 3'd4,
      CFG_BROKE   = 3'd5,
      CFG_SEED    = 3'd6
   } cfg_idx_type;

   typedef enum logic [2:0] {
      RES_ZERO,
      RES_ADD,
      RES_BID_OK,
      RES_IDLE,
      RES_GRANT
   } res_kind_type;

   typedef enum logic [1:0] {
      WIN_NEW,
      WIN_RR,
      WIN_BID
   } win_src_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_OP,
      S_SB_CHK,
      S_CH_WR,
      S_REFILL,
      S_SCAN,
      S_DECIDE,
      S_DIV,
      S_PICK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic          capture;
      logic          rd_slot;
      logic          do_add;
      logic          do_setbid;
      logic          ok_load;
      logic          do_setready;
      logic          do_charge;
      logic          do_refill;
      logic          idx_clr;
      logic          scan_rd;
      logic          win_load;
      win_src_type   win_src;
      logic          rr_upd;
      logic          div_start;
      logic          div_step;
      logic          pick_step;
      logic          finish;
      res_kind_type  res_kind;
      op_status_type res_status;
   } cmd_type;

   typedef struct packed {
      op_type   op;
      logic     full;
      logic     registered;
      logic     idx_end;
      logic     rd_vld;
      logic     found_new;
      logic     nready_zero;
      mode_type mode;
      logic     any_active;
      logic     hv;
      logic     div_last;
      logic     pick_hit;
   } stat_type;

endpackage

@@ rtl/bba_datapath.sv @@
// Datapath of the bid budget arbiter: requester table, config registers, scan, divider.
// Depends on bba_pkg; driven by bba_controller through cmd_type.
`timescale 1ns / 1ps

module bba_datapath (
   input  logic              clock,
   input  logic              reset,
   input  bba_pkg::cmd_type  cmd,
   output bba_pkg::stat_type st,
   input  logic [23:0]       req_tdata,
   input  logic              csr_we,
   input  logic [2:0]        csr_addr,
   input  logic [31:0]       csr_wdata,
   output logic [15:0]       rsp_tdata
);

   localparam int IW = bba_pkg::IDX_W;
   localparam int CW = bba_pkg::CNT_W;

   // Captured request.
   bba_pkg::op_type    op_ff;
   logic [3:0]         slot_ff;
   logic signed [15:0] bidv_ff;
   logic               rdy_ff;

   // Configuration.
   bba_pkg::mode_type  mode_ff;
   logic signed [15:0] min_ff, max_ff, init_ff;
   logic [30:0]        refill_ff;
   logic signed [31:0] broke_ff;

   // Table state.
   logic signed [15:0] bid_mem [bba_pkg::SLOTS];
   logic signed [31:0] bal_mem [bba_pkg::SLOTS];
   logic [1:0]         ph_mem  [bba_pkg::SLOTS];
   logic [bba_pkg::SLOTS-1:0] ready_ff;
   logic [CW-1:0]      cnt_ff;
   logic [IW-1:0]      rr_ff;
   logic [15:0]        lfsr_ff;

   // Read port and scan bookkeeping.
   logic signed [15:0] bid_rd_ff;
   logic signed [31:0] bal_rd_ff;
   logic [1:0]         ph_rd_ff;
   logic [CW-1:0]      idx_ff;
   logic               rd_vld_ff;
   logic [IW-1:0]      rd_idx_ff;
   logic               act_ff, fnd_ff, hv_ff, sv_ff, ok_ff;
   logic [IW-1:0]      nwin_ff, hi_ff, se_ff, win_ff;
   logic signed [15:0] hib_ff, seb_ff;
   logic [CW-1:0]      rem_ff;
   logic [15:0]        dsh_ff;
   logic [3:0]         dcnt_ff;

   logic [IW-1:0]      rd_addr, slot_idx, rr_win, rr_in;
   logic [CW-1:0]      nready, rr_start;
   logic [15:0]        lfsr_in;
   logic [CW:0]        trial;
   logic [CW-1:0]      rem_in;
   logic               cand, scan_new;
   logic signed [33:0] diff;
   logic signed [31:0] bal_in;
   logic [1:0]         ph_in;
   logic [bba_pkg::SLOTS-1:0] live_mask;
   logic [15:0]        rsp_data_in;

   function automatic logic bid_valid(input logic signed [15:0] b,
                                      input logic signed [31:0] bal,
                                      input logic signed [15:0] lo,
                                      input logic signed [15:0] hi);
      logic signed [31:0] bx;
      bx = {{16{b[15]}}, b};
      return (b >= lo) && (b <= hi) && (bx <= bal);
   endfunction

   assign slot_idx = slot_ff[IW-1:0];
   assign rd_addr  = cmd.rd_slot ? slot_idx : idx_ff[IW-1:0];
   assign lfsr_in  = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ bba_pkg::LFSR_TAPS) : (lfsr_ff >> 1);

   always_comb begin
      nready = '0;
      live_mask = '0;
      for (int i = 0; i < bba_pkg::SLOTS; i++) begin
         nready = nready + CW'(ready_ff[i]);
         live_mask[i] = (CW'(i) < cnt_ff);
      end
   end

   // Round robin: first ready entry at or after the start, else the first ready overall.
   always_comb begin
      logic hit_hi, hit_lo;
      logic [IW-1:0] w_hi, w_lo;
      hit_hi = 1'b0;
      hit_lo = 1'b0;
      w_hi = '0;
      w_lo = '0;
      rr_start = ({1'b0, rr_ff} < cnt_ff) ? CW'(rr_ff) : '0;
      for (int i = bba_pkg::SLOTS - 1; i >= 0; i--) begin
         if (ready_ff[i]) begin
            hit_lo = 1'b1;
            w_lo = IW'(i);
            if (CW'(i) >= rr_start) begin
               hit_hi = 1'b1;
               w_hi = IW'(i);
            end
         end
      end
      rr_win = hit_hi ? w_hi : w_lo;
      rr_in  = ({1'b0, rr_win} + CW'(1) >= cnt_ff) ? '0 : rr_win + IW'(1);
   end

   assign cand = ready_ff[rd_idx_ff] && (ph_rd_ff == bba_pkg::PH_ACTIVE)
                 && bid_valid(bid_rd_ff, bal_rd_ff, min_ff, max_ff);
   assign scan_new = ready_ff[rd_idx_ff] && (ph_rd_ff == bba_pkg::PH_NEW);

   assign trial  = {rem_ff, dsh_ff[15]};
   assign rem_in = (trial >= {1'b0, nready}) ? CW'(trial - {1'b0, nready}) : trial[CW-1:0];

   // Charge of a run.
   always_comb begin
      diff = {{2{bal_rd_ff[31]}}, bal_rd_ff} - {{18{bid_rd_ff[15]}}, bid_rd_ff};
      bal_in = bal_rd_ff;
      ph_in = ph_rd_ff;
      if (ph_rd_ff == bba_pkg::PH_NEW) begin
         ph_in = bba_pkg::PH_ACTIVE;
      end else if (diff <= 34'sd0) begin
         bal_in = broke_ff;
         ph_in = bba_pkg::PH_BROKE;
      end else if (diff > 34'sd2147483647) begin
         bal_in = 32'sh7FFFFFFF;
      end else begin
         bal_in = diff[31:0];
      end
   end

   // Result word for the current operation.
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[8:7] = cmd.res_status;
      unique case (cmd.res_kind)
         bba_pkg::RES_ADD:    rsp_data_in[3:0] = 4'(win_ff);
         bba_pkg::RES_BID_OK: rsp_data_in[6] = ok_ff;
         bba_pkg::RES_IDLE:   rsp_data_in[5] = 1'b1;
         bba_pkg::RES_GRANT: begin
            rsp_data_in[3:0] = 4'(win_ff);
            rsp_data_in[4] = 1'b1;
         end
         default: ;
      endcase
   end

   // Table memories: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      bid_rd_ff <= bid_mem[rd_addr];
      bal_rd_ff <= bal_mem[rd_addr];
      ph_rd_ff  <= ph_mem[rd_addr];
      if (cmd.do_add && !st.full) begin
         bid_mem[cnt_ff[IW-1:0]] <= init_ff;
         bal_mem[cnt_ff[IW-1:0]] <= {1'b0, refill_ff};
         ph_mem[cnt_ff[IW-1:0]]  <= bba_pkg::PH_NEW;
      end else if (cmd.do_setbid) begin
         bid_mem[slot_idx] <= bidv_ff;
      end else if (cmd.do_charge) begin
         bal_mem[slot_idx] <= bal_in;
         ph_mem[slot_idx]  <= ph_in;
      end else if (cmd.do_refill) begin
         bal_mem[idx_ff[IW-1:0]] <= {1'b0, refill_ff};
         ph_mem[idx_ff[IW-1:0]]  <= bba_pkg::PH_ACTIVE;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= bba_pkg::op_type'(req_tdata[2:0]);
         slot_ff <= req_tdata[6:3];
         bidv_ff <= req_tdata[22:7];
         rdy_ff  <= req_tdata[23];
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
         act_ff <= 1'b0;
         fnd_ff <= 1'b0;
         hv_ff  <= 1'b0;
         sv_ff  <= 1'b0;
      end else if (cmd.scan_rd || cmd.do_refill || cmd.pick_step) begin
         idx_ff <= idx_ff + CW'(1);
      end
      rd_idx_ff <= idx_ff[IW-1:0];
      if (rd_vld_ff) begin
         if (ph_rd_ff == bba_pkg::PH_ACTIVE) act_ff <= 1'b1;
         if (!fnd_ff && scan_new) begin
            fnd_ff  <= 1'b1;
            nwin_ff <= rd_idx_ff;
         end
         if (cand) begin
            if (!hv_ff || bid_rd_ff > hib_ff) begin
               if (hv_ff) begin
                  se_ff  <= hi_ff;
                  seb_ff <= hib_ff;
                  sv_ff  <= 1'b1;
               end
               hi_ff  <= rd_idx_ff;
               hib_ff <= bid_rd_ff;
               hv_ff  <= 1'b1;
            end else if (!sv_ff || bid_rd_ff > seb_ff) begin
               se_ff  <= rd_idx_ff;
               seb_ff <= bid_rd_ff;
               sv_ff  <= 1'b1;
            end
         end
      end
      if (cmd.ok_load) ok_ff <= bid_valid(bidv_ff, bal_rd_ff, min_ff, max_ff);
      if (cmd.do_add) win_ff <= cnt_ff[IW-1:0];
      if (cmd.win_load) begin
         unique case (cmd.win_src)
            bba_pkg::WIN_NEW: win_ff <= nwin_ff;
            bba_pkg::WIN_RR:  win_ff <= rr_win;
            bba_pkg::WIN_BID: win_ff <= (mode_ff == bba_pkg::MODE_SECOND && sv_ff) ? se_ff : hi_ff;
            default:          win_ff <= hi_ff;
         endcase
      end
      if (cmd.div_start) begin
         dsh_ff  <= lfsr_in;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dsh_ff  <= {dsh_ff[14:0], 1'b0};
         rem_ff  <= rem_in;
         dcnt_ff <= dcnt_ff + 4'd1;
      end else if (cmd.pick_step && ready_ff[idx_ff[IW-1:0]]) begin
         if (rem_ff == '0) win_ff <= idx_ff[IW-1:0];
         else rem_ff <= rem_ff - CW'(1);
      end
      if (cmd.finish) rsp_tdata <= rsp_data_in;
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= bba_pkg::MODE_HIGHEST;
         min_ff    <= 16'sd1;
         max_ff    <= 16'sd1000;
         init_ff   <= -16'sd1;
         refill_ff <= 31'd1000;
         broke_ff  <= -32'sd1;
         lfsr_ff   <= 16'd44257;
         ready_ff  <= '0;
         cnt_ff    <= '0;
         rr_ff     <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.scan_rd;
         if (csr_we) begin
            unique case (bba_pkg::cfg_idx_type'(csr_addr))
               bba_pkg::CFG_MODE:    mode_ff   <= bba_pkg::mode_type'(csr_wdata[1:0]);
               bba_pkg::CFG_MIN_BID: min_ff    <= csr_wdata[15:0];
               bba_pkg::CFG_MAX_BID: max_ff    <= csr_wdata[15:0];
               bba_pkg::CFG_INIT:    init_ff   <= csr_wdata[15:0];
               bba_pkg::CFG_REFILL:  refill_ff <= csr_wdata[30:0];
               bba_pkg::CFG_BROKE:   broke_ff  <= csr_wdata;
               bba_pkg::CFG_SEED:
                  lfsr_ff <= (csr_wdata[15:0] == 16'd0) ? 16'd1 : csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.do_add && !st.full) begin
            ready_ff[cnt_ff[IW-1:0]] <= 1'b0;
            cnt_ff <= cnt_ff + CW'(1);
         end
         if (cmd.do_setready) ready_ff[slot_idx] <= rdy_ff;
         if (cmd.rr_upd) rr_ff <= rr_in;
         if (cmd.div_start) lfsr_ff <= lfsr_in;
      end
   end

   always_comb begin
      st.op          = op_ff;
      st.full        = (cnt_ff >= CW'(bba_pkg::SLOTS));
      st.registered  = ({1'b0, slot_ff} < cnt_ff);
      st.idx_end     = (idx_ff >= cnt_ff);
      st.rd_vld      = rd_vld_ff;
      st.found_new   = fnd_ff;
      st.nready_zero = (nready == '0);
      st.mode        = mode_ff;
      st.any_active  = act_ff;
      st.hv          = hv_ff;
      st.div_last    = (dcnt_ff == 4'(bba_pkg::DIV_STEPS - 1));
      st.pick_hit    = ready_ff[idx_ff[IW-1:0]] && (rem_ff == '0);
   end

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(bba_pkg::SLOTS))
      else $error("requester count beyond table size");
   a_ready_live: assert property (@(posedge clock) disable iff (reset)
      (ready_ff & ~live_mask) == '0)
      else $error("ready flag set on an unregistered slot");
   a_grant_live: assert property (@(posedge clock) disable iff (reset)
      cmd.finish && cmd.res_kind == bba_pkg::RES_GRANT |-> CW'(win_ff) < cnt_ff)
      else $error("grant of an unregistered slot");
   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> rem_ff < nready)
      else $error("remainder not below divisor");
`endif

endmodule

@@ rtl/bba_controller.sv @@
// Sequencing state machine of the bid budget arbiter.
// Depends on bba_pkg; issues cmd_type to bba_datapath and reads stat_type back.
`timescale 1ns / 1ps

module bba_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  bba_pkg::stat_type st,
   output bba_pkg::cmd_type  cmd
);

   bba_pkg::state_type      state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bba_pkg::res_kind_type   kind_ff, kind_in;
   bba_pkg::op_status_type  stat_ff, stat_in;
   logic                    random_pick;

   assign random_pick = (st.mode == bba_pkg::MODE_RANDOM)
                        || ((st.mode == bba_pkg::MODE_HIGHEST || st.mode == bba_pkg::MODE_SECOND)
                            && !st.any_active);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         kind_ff      <= bba_pkg::RES_ZERO;
         stat_ff      <= bba_pkg::STAT_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         kind_ff      <= kind_in;
         stat_ff      <= stat_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      kind_in = kind_ff;
      stat_in = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd = '0;
      cmd.res_kind = kind_ff;
      cmd.res_status = stat_ff;
      cmd.win_src = bba_pkg::WIN_NEW;
      req_tready = (state_ff == bba_pkg::S_IDLE);
      unique case (state_ff)
         bba_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = bba_pkg::S_OP;
            end
         end
         bba_pkg::S_OP: begin
            cmd.rd_slot = 1'b1;
            cmd.idx_clr = 1'b1;
            kind_in = bba_pkg::RES_ZERO;
            stat_in = bba_pkg::STAT_OK;
            state_in = bba_pkg::S_FINISH;
            unique case (st.op)
               bba_pkg::OP_ADD: begin
                  cmd.do_add = 1'b1;
                  if (st.full) stat_in = bba_pkg::STAT_FULL;
                  else kind_in = bba_pkg::RES_ADD;
               end
               bba_pkg::OP_SET_BID: begin
                  if (!st.registered) stat_in = bba_pkg::STAT_UNREG;
                  else begin
                     cmd.do_setbid = 1'b1;
                     kind_in = bba_pkg::RES_BID_OK;
                     state_in = bba_pkg::S_SB_CHK;
                  end
               end
               bba_pkg::OP_SET_RDY: begin
                  if (!st.registered) stat_in = bba_pkg::STAT_UNREG;
                  else cmd.do_setready = 1'b1;
               end
               bba_pkg::OP_CHARGE: begin
                  if (!st.registered) stat_in = bba_pkg::STAT_UNREG;
                  else state_in = bba_pkg::S_CH_WR;
               end
               bba_pkg::OP_REFILL: state_in = bba_pkg::S_REFILL;
               bba_pkg::OP_GRANT:  state_in = bba_pkg::S_SCAN;
               default: ;
            endcase
         end
         bba_pkg::S_SB_CHK: begin
            cmd.ok_load = 1'b1;
            state_in = bba_pkg::S_FINISH;
         end
         bba_pkg::S_CH_WR: begin
            cmd.do_charge = 1'b1;
            state_in = bba_pkg::S_FINISH;
         end
         bba_pkg::S_REFILL: begin
            if (st.idx_end) state_in = bba_pkg::S_FINISH;
            else cmd.do_refill = 1'b1;
         end
         bba_pkg::S_SCAN: begin
            if (!st.idx_end) cmd.scan_rd = 1'b1;
            else if (!st.rd_vld) state_in = bba_pkg::S_DECIDE;
         end
         bba_pkg::S_DECIDE: begin
            state_in = bba_pkg::S_FINISH;
            priority if (st.found_new) begin
               cmd.win_load = 1'b1;
               cmd.win_src = bba_pkg::WIN_NEW;
               kind_in = bba_pkg::RES_GRANT;
            end else if (st.nready_zero) begin
               kind_in = bba_pkg::RES_IDLE;
            end else if (random_pick) begin
               cmd.div_start = 1'b1;
               state_in = bba_pkg::S_DIV;
            end else if (st.mode == bba_pkg::MODE_RR) begin
               cmd.win_load = 1'b1;
               cmd.win_src = bba_pkg::WIN_RR;
               cmd.rr_upd = 1'b1;
               kind_in = bba_pkg::RES_GRANT;
            end else if (st.hv) begin
               cmd.win_load = 1'b1;
               cmd.win_src = bba_pkg::WIN_BID;
               kind_in = bba_pkg::RES_GRANT;
            end else begin
               kind_in = bba_pkg::RES_ZERO;
            end
         end
         bba_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_last) begin
               cmd.idx_clr = 1'b1;
               state_in = bba_pkg::S_PICK;
            end
         end
         bba_pkg::S_PICK: begin
            cmd.pick_step = 1'b1;
            if (st.pick_hit) begin
               kind_in = bba_pkg::RES_GRANT;
               state_in = bba_pkg::S_FINISH;
            end
         end
         bba_pkg::S_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: state_in = bba_pkg::S_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_finish_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_tvalid)
      else $error("finished result not presented");
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == bba_pkg::S_OP)
      else $error("accepted item not dispatched");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rsp_valid_ff || rsp_tready)
      else $error("pending result overwritten");
`endif

endmodule

@@ rtl/bid_budget_arbiter_top.sv @@
// Top level of the bid budget arbiter: joins the controller and the datapath.
// Depends on bba_pkg, bba_controller and bba_datapath.
`timescale 1ns / 1ps
//
//  Channel  Direction  Ports                        Content
//  req      in         req_tvalid/tready/tdata      one operation per transfer
//  rsp      out        rsp_tvalid/tready/tdata      one result per operation
//  csr      in         csr_we/csr_addr/csr_wdata    register write, no read-back
//
// An operation is taken only while the block is idle. Set-bid adds a bid check and charge a
// table write; refill writes every registered requester in turn. A grant scans the table
// once and then decides; a random pick adds a remainder divider and a walk over the ready
// requesters up to the selected one.
// The result sits in an output register, so the next operation is accepted while it waits.
// Reset is synchronous and active high; the table contents are written by add before use.

module bid_budget_arbiter_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // op[2:0], slot[6:3], bid_value[22:7], ready_in[23]
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // granted_slot[3:0], grant_valid[4], idle_grant[5], bid_ok[6], op_status[8:7]
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [31:0] csr_wdata
);

   // Commands flow from the controller; status flows back from the datapath.
   bba_pkg::cmd_type  cmd;
   bba_pkg::stat_type st;

   bba_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .st         (st),
      .cmd        (cmd)
   );

   bba_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .st        (st),
      .req_tdata (req_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ sim/bid_budget_arbiter_top_tb.sv @@
// Self-checking testbench for the bid budget arbiter top level: directed and random operations,
// predicted results compared with every response transfer.
// Depends on bba_pkg and bid_budget_arbiter_top.
`timescale 1ns / 1ps

module bid_budget_arbiter_top_tb;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_we;
   logic [2:0]  csr_addr;
   logic [31:0] csr_wdata;

   // One expected response; members run from the top bit of rsp_tdata[8:0] down.
   typedef struct packed {
      bba_pkg::op_status_type status;
      logic                   ok;
      logic                   gidle;
      logic                   gvalid;
      logic [3:0]             slot;
   } arb_result_type;

   arb_result_type pending_results[$];
   int          error_count;
   int          idle_cycles;
   bit          stall_enable;
   bit          sim_done;

   // Shadow copy of the arbiter table and registers.
   logic signed [15:0]  shadow_bid[bba_pkg::SLOTS];
   logic signed [31:0]  shadow_balance[bba_pkg::SLOTS];
   bba_pkg::phase_type  shadow_phase[bba_pkg::SLOTS];
   logic                shadow_ready[bba_pkg::SLOTS];
   int                  shadow_count;
   int                  shadow_rr;
   logic [15:0]         shadow_lfsr;
   bba_pkg::mode_type   cur_mode;
   logic signed [15:0]  cur_min_bid;
   logic signed [15:0]  cur_max_bid;
   logic signed [15:0]  cur_init_bid;
   logic [30:0]         cur_refill;
   logic signed [31:0]  cur_broke;

   bid_budget_arbiter_top u_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit bid_is_valid(int i);
      return shadow_bid[i] >= cur_min_bid && shadow_bid[i] <= cur_max_bid &&
             32'(shadow_bid[i]) <= shadow_balance[i];
   endfunction

   // Steps the LFSR and returns the chosen entry among the ready requesters, in index order.
   function automatic int pick_random_ready(int nready);
      int k;
      shadow_lfsr = shadow_lfsr[0] ? ((shadow_lfsr >> 1) ^ bba_pkg::LFSR_TAPS)
                                   : (shadow_lfsr >> 1);
      k = int'(shadow_lfsr) % nready;
      for (int i = 0; i < shadow_count; i++) begin
         if (shadow_ready[i]) begin
            if (k == 0) return i;
            k--;
         end
      end
      return 0;
   endfunction

   function automatic arb_result_type predict_op(logic [2:0] op, logic [3:0] slot,
                                                 logic signed [15:0] bidv, logic rdy);
      arb_result_type r;
      int nready, win, hi, se;
      bit found, any_active, hv, sv, registered;
      longint nb;
      r = '0;
      registered = int'(slot) < shadow_count;
      case (op)
         bba_pkg::OP_ADD: begin
            if (shadow_count >= bba_pkg::SLOTS) begin
               r.status = bba_pkg::STAT_FULL;
            end else begin
               shadow_bid[shadow_count] = cur_init_bid;
               shadow_balance[shadow_count] = {1'b0, cur_refill};
               shadow_phase[shadow_count] = bba_pkg::PH_NEW;
               shadow_ready[shadow_count] = 1'b0;
               r.slot = 4'(shadow_count);
               shadow_count++;
            end
         end
         bba_pkg::OP_SET_BID, bba_pkg::OP_SET_RDY, bba_pkg::OP_CHARGE: begin
            if (!registered) begin
               r.status = bba_pkg::STAT_UNREG;
            end else if (op == bba_pkg::OP_SET_BID) begin
               shadow_bid[slot] = bidv;
               r.ok = bid_is_valid(slot);
            end else if (op == bba_pkg::OP_SET_RDY) begin
               shadow_ready[slot] = rdy;
            end else if (shadow_phase[slot] == bba_pkg::PH_NEW) begin
               shadow_phase[slot] = bba_pkg::PH_ACTIVE;
            end else begin
               nb = longint'(shadow_balance[slot]) - longint'(shadow_bid[slot]);
               if (nb > 64'sd2147483647) nb = 64'sd2147483647;
               if (nb <= 0) begin
                  shadow_balance[slot] = cur_broke;
                  shadow_phase[slot] = bba_pkg::PH_BROKE;
               end else begin
                  shadow_balance[slot] = 32'(nb);
               end
            end
         end
         bba_pkg::OP_REFILL: begin
            for (int i = 0; i < shadow_count; i++) begin
               shadow_balance[i] = {1'b0, cur_refill};
               shadow_phase[i] = bba_pkg::PH_ACTIVE;
            end
         end
         bba_pkg::OP_GRANT: begin
            nready = 0; win = 0; found = 0; any_active = 0;
            for (int i = 0; i < shadow_count; i++) begin
               if (shadow_ready[i]) nready++;
               if (shadow_phase[i] == bba_pkg::PH_ACTIVE) any_active = 1;
               if (!found && shadow_ready[i] && shadow_phase[i] == bba_pkg::PH_NEW) begin
                  found = 1;
                  win = i;
               end
            end
            if (!found && nready == 0) begin
               r.gidle = 1'b1;
            end else if (!found) begin
               if (cur_mode == bba_pkg::MODE_RANDOM ||
                   (cur_mode inside {bba_pkg::MODE_HIGHEST, bba_pkg::MODE_SECOND} &&
                    !any_active)) begin
                  win = pick_random_ready(nready);
                  found = 1;
               end else if (cur_mode == bba_pkg::MODE_RR) begin
                  for (int j = 0; j < shadow_count && !found; j++) begin
                     int k;
                     k = (shadow_rr < shadow_count ? shadow_rr : 0) + j;
                     if (k >= shadow_count) k -= shadow_count;
                     if (shadow_ready[k]) begin
                        win = k;
                        found = 1;
                     end
                  end
                  shadow_rr = (win + 1 >= shadow_count) ? 0 : win + 1;
               end else begin
                  hv = 0; sv = 0; hi = 0; se = 0;
                  for (int i = 0; i < shadow_count; i++) begin
                     if (!(shadow_ready[i] && shadow_phase[i] == bba_pkg::PH_ACTIVE &&
                           bid_is_valid(i)))
                        continue;
                     if (!hv || shadow_bid[i] > shadow_bid[hi]) begin
                        if (hv) begin
                           se = hi;
                           sv = 1;
                        end
                        hi = i;
                        hv = 1;
                     end else if (!sv || shadow_bid[i] > shadow_bid[se]) begin
                        se = i;
                        sv = 1;
                     end
                  end
                  if (hv) begin
                     found = 1;
                     win = (cur_mode == bba_pkg::MODE_SECOND && sv) ? se : hi;
                  end
               end
            end
            if (found) begin
               r.gvalid = 1'b1;
               r.slot = 4'(win);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // Sends one operation and queues its predicted result once the transfer happens.
   // After the transfer the task waits on the clock again so that the next item starts in a later time step.
   task automatic send_op(logic [2:0] op, logic [3:0] slot = 0,
                          logic signed [15:0] bidv = 0, logic rdy = 0);
      if (stall_enable && $urandom_range(0, 3) == 0) begin
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {rdy, bidv, slot, op};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(predict_op(op, slot, bidv, rdy));
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   // Register writes happen only with nothing in flight.
   task automatic write_reg(bba_pkg::cfg_idx_type idx, logic [31:0] value);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         bba_pkg::CFG_MODE:    cur_mode = bba_pkg::mode_type'(value[1:0]);
         bba_pkg::CFG_MIN_BID: cur_min_bid = value[15:0];
         bba_pkg::CFG_MAX_BID: cur_max_bid = value[15:0];
         bba_pkg::CFG_INIT:    cur_init_bid = value[15:0];
         bba_pkg::CFG_REFILL:  cur_refill = value[30:0];
         bba_pkg::CFG_BROKE:   cur_broke = value;
         bba_pkg::CFG_SEED:    shadow_lfsr = (value[15:0] == 0) ? 16'd1 : value[15:0];
         default: ;
      endcase
   endtask

   // Response checker: every accepted transfer is compared with the oldest prediction.
   always @(posedge clock) begin
      arb_result_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = arb_result_type'(rsp_tdata[8:0]);
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result %h", $time, rsp_tdata);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (got.slot !== want.slot || got.gvalid !== want.gvalid ||
                got.gidle !== want.gidle || got.ok !== want.ok ||
                got.status !== want.status) begin
               $display("%0t: mismatch expected slot=%0d gv=%b idle=%b ok=%b st=%0d",
                        $time, want.slot, want.gvalid, want.gidle, want.ok, want.status);
               $display("%0t:          actual   slot=%0d gv=%b idle=%b ok=%b st=%0d",
                        $time, got.slot, got.gvalid, got.gidle, got.ok, got.status);
               error_count++;
            end
         end
      end
   end

   // Receiver back-pressure in random bursts, switched off for the last part of the run.
   initial begin
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         if (stall_enable && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 20)) @(posedge clock);
      end
   end

   // Watchdog: too long without any transfer ends the run.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else if (!sim_done)
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL bid_budget_arbiter_top");
         $finish;
      end
   end

   task automatic fill_table(int n);
      for (int i = 0; i < n; i++) send_op(bba_pkg::OP_ADD);
   endtask

   // Directed: extremes of every field, each op, full table, unregistered slots, free first
   // charge, broke, refill, idle grant and unused codes.
   task automatic test_directed();
      send_op(bba_pkg::OP_GRANT);                     // nobody registered: idle grant
      send_op(bba_pkg::OP_SET_BID, 4'd15, 16'sh7FFF, 1'b1);
      send_op(bba_pkg::OP_CHARGE, 4'd0);
      fill_table(bba_pkg::SLOTS);
      send_op(bba_pkg::OP_ADD);                       // full table
      send_op(bba_pkg::OP_SET_BID, 4'd0, 16'sh8000);  // below min
      send_op(bba_pkg::OP_SET_BID, 4'd1, 16'sh7FFF);  // above max
      send_op(bba_pkg::OP_SET_BID, 4'd2, 16'sd500);
      send_op(bba_pkg::OP_SET_RDY, 4'd15, 0, 1'b1);
      send_op(bba_pkg::OP_SET_RDY, 4'd2, 0, 1'b1);
      send_op(bba_pkg::OP_GRANT);                     // new requester wins first
      send_op(bba_pkg::OP_CHARGE, 4'd15);             // free run
      send_op(bba_pkg::OP_CHARGE, 4'd2);
      send_op(bba_pkg::OP_CHARGE, 4'd2);
      send_op(bba_pkg::OP_CHARGE, 4'd2);              // goes broke
      send_op(bba_pkg::OP_GRANT);
      send_op(bba_pkg::OP_REFILL);
      send_op(bba_pkg::OP_GRANT);
      send_op(3'd6, 4'd15, 16'shFFFF, 1'b1);
      send_op(3'd7);
      send_op(bba_pkg::OP_SET_RDY, 4'd2, 0, 1'b0);
      send_op(bba_pkg::OP_SET_RDY, 4'd15, 0, 1'b0);
      send_op(bba_pkg::OP_GRANT);
   endtask

   // One random operation; mostly against registered slots so the table stays busy.
   task automatic random_op(int grant_weight);
      int sel;
      logic [3:0] slot;
      logic signed [15:0] bidv;
      sel = $urandom_range(0, 99);
      slot = (shadow_count > 0 && $urandom_range(0, 9) != 0) ?
             4'($urandom_range(0, shadow_count - 1)) : 4'($urandom);
      bidv = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1100));
      if (sel < 4)                    send_op(bba_pkg::OP_ADD);
      else if (sel < 30)              send_op(bba_pkg::OP_SET_BID, slot, bidv);
      else if (sel < 50)              send_op(bba_pkg::OP_SET_RDY, slot, 0,
                                              $urandom_range(0, 3) != 0);
      else if (sel < 50 + grant_weight) send_op(bba_pkg::OP_GRANT);
      else if (sel < 96)              send_op(bba_pkg::OP_CHARGE, slot);
      else if (sel < 98)              send_op(bba_pkg::OP_REFILL);
      else                            send_op(3'($urandom_range(6, 7)), slot, bidv, 1'($urandom));
   endtask

   // Each mode in turn, with varied limits and budgets; the table is never rebuilt and stays
   // full from the directed test, so every phase runs with all requesters registered.
   task automatic test_modes();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(bba_pkg::CFG_MODE, 32'(phase % 4));
         write_reg(bba_pkg::CFG_MIN_BID, (phase == 3) ? 32'hFFFF8000 : $urandom_range(0, 50));
         write_reg(bba_pkg::CFG_MAX_BID,
                   (phase == 5) ? 32'h00007FFF : $urandom_range(300, 1000));
         write_reg(bba_pkg::CFG_INIT, (phase == 2) ? 32'h00007FFF : 32'($urandom_range(0, 400)));
         write_reg(bba_pkg::CFG_REFILL, (phase == 6) ? 32'h7FFFFFFF :
                                        (phase == 1) ? 32'd0 : $urandom_range(200, 3000));
         write_reg(bba_pkg::CFG_BROKE, (phase == 4) ? 32'h80000000 :
                                       (phase == 7) ? 32'h7FFFFFFF : $urandom);
         write_reg(bba_pkg::CFG_SEED,
                   (phase == 0) ? 32'd0 : (phase == 1) ? 32'hFFFF : $urandom);
         if (phase == 7) stall_enable = 1'b0;
         for (int n = 0; n < 189; n++) random_op(25);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      error_count = 0;
      idle_cycles = 0;
      sim_done = 1'b0;
      stall_enable = 1'b1;
      shadow_count = 0;
      shadow_rr = 0;
      shadow_lfsr = 16'd44257;
      cur_mode = bba_pkg::MODE_HIGHEST;
      cur_min_bid = 16'sd1;
      cur_max_bid = 16'sd1000;
      cur_init_bid = -16'sd1;
      cur_refill = 31'd1000;
      cur_broke = -32'sd1;
      for (int i = 0; i < bba_pkg::SLOTS; i++) shadow_ready[i] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_modes();

      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      sim_done = 1'b1;
      if (error_count == 0) begin
         $display("PASS bid_budget_arbiter_top");
      end else begin
         $display("FAIL bid_budget_arbiter_top");
      end
      $finish;
   end

endmodule

@@ bid_budget_arbiter_top.f @@
rtl/bba_pkg.sv
rtl/bba_datapath.sv
rtl/bba_controller.sv
rtl/bid_budget_arbiter_top.sv
sim/bid_budget_arbiter_top_tb.sv
